>>> rtl/bset_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bset_pkg
// types and constants shared by the bounded unique set block: beat payloads,
// operation codes and the controller command group
// ----------------------------------------------------------------------------
package bset_pkg;

  // operation codes
  typedef enum logic [1:0] {
    OP_ADD    = 2'd0,
    OP_REMOVE = 2'd1,
    OP_MEMBER = 2'd2,
    OP_READ   = 2'd3
  } op_t;

  // capacity register after reset
  localparam logic [5:0] CAP_RESET = 6'd10;

  // input beat
  typedef struct packed {
    op_t                operation;
    logic signed [31:0] value;
    logic        [4:0]  index;
  } in_item_t;

  // result beat
  typedef struct packed {
    logic               found;
    logic               stored;
    logic        [5:0]  count;
    logic signed [31:0] entry_value;
  } out_item_t;

  // controller to datapath
  typedef struct packed {
    logic load;    // capture input beat and lane match vector
    logic commit;  // apply operation and write result register
  } ctrl_cmd_t;

endpackage
`default_nettype wire

>>> rtl/bset_dp.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bset_dp
// datapath: entry lanes with per-lane compare, registered match vector,
// append / compaction shift, capacity register and result register
// ----------------------------------------------------------------------------
module bset_dp
  import bset_pkg::*;
#(
  parameter int DEPTH = 32
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire ctrl_cmd_t cmd,
  input  wire in_item_t  in_data,
  input  wire logic      cfg_wr_en,
  input  wire logic [5:0] cfg_wr_data,
  output out_item_t      out_data
);

  localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam int KW = (CW > 6) ? CW : 6;

  logic signed [31:0] cells_r [DEPTH];
  logic [DEPTH-1:0]   match_r;
  logic [DEPTH-1:0]   match_nxt;
  logic [DEPTH-1:0]   shift_mask;
  logic [CW-1:0]      count_r;
  logic [CW-1:0]      count_nxt;
  logic [5:0]         cap_r;
  op_t                op_r;
  logic signed [31:0] value_r;
  logic [4:0]         index_r;
  out_item_t          res_r;
  out_item_t          res_nxt;

  logic          hit;
  logic          add_ok;
  logic          rd_ok;
  logic [KW-1:0] count_ext;
  logic [KW-1:0] cap_ext;
  logic [KW-1:0] cap_eff;
  logic [IW-1:0] wr_addr;
  logic [IW-1:0] rd_addr;

  // lane compare against the incoming value, live lanes only
  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      match_nxt[i] = (CW'(i) < count_r) && (cells_r[i] == in_data.value);
    end
  end

  assign hit        = |match_r;
  // lanes at and above the single matching lane
  assign shift_mask = ~(match_r - DEPTH'(1));
  assign count_ext  = KW'(count_r);
  assign cap_ext    = KW'(cap_r);
  assign cap_eff    = (cap_ext > KW'(DEPTH)) ? KW'(DEPTH) : cap_ext;
  assign add_ok     = (op_r == OP_ADD) && !hit && (count_ext < cap_eff);
  assign rd_ok      = (op_r == OP_READ) && (KW'(index_r) < count_ext);
  assign wr_addr    = IW'(count_r);
  assign rd_addr    = IW'(index_r);

  always_comb begin
    count_nxt = count_r;
    if (add_ok) begin
      count_nxt = count_r + CW'(1);
    end else if ((op_r == OP_REMOVE) && hit) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_comb begin
    res_nxt.found       = (op_r == OP_READ) ? rd_ok : hit;
    res_nxt.stored      = add_ok;
    res_nxt.count       = 6'(count_nxt);
    res_nxt.entry_value = rd_ok ? cells_r[rd_addr] : 32'sd0;
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      cap_r   <= CAP_RESET;
      match_r <= '0;
    end else begin
      if (cfg_wr_en) begin
        cap_r <= cfg_wr_data;
      end
      if (cmd.load) begin
        match_r <= match_nxt;
      end
      if (cmd.commit) begin
        count_r <= count_nxt;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r    <= in_data.operation;
      value_r <= in_data.value;
      index_r <= in_data.index;
    end
    if (cmd.commit) begin
      res_r <= res_nxt;
      case (op_r)
        OP_ADD: begin
          if (add_ok) begin
            cells_r[wr_addr] <= value_r;
          end
        end
        OP_REMOVE: begin
          if (hit) begin
            for (int i = 0; i < DEPTH - 1; i++) begin
              if (shift_mask[i]) begin
                cells_r[i] <= cells_r[i+1];
              end
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  assign out_data = res_r;

`ifndef ASSERT_OFF
  // values are unique, so at most one lane can match
  a_match_unique: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(match_r))
    else $error("more than one lane matched");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(DEPTH))
    else $error("entry count beyond depth");

  a_count_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !cmd.commit |=> $stable(count_r))
    else $error("entry count moved without a commit");
`endif

endmodule
`default_nettype wire

>>> rtl/bset_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bset_ctrl
// controller: accepts one beat, then commits it into the result register
// once that register is free; owns the result valid flag
// ----------------------------------------------------------------------------
module bset_ctrl
  import bset_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_valid,
  output logic      in_stall,
  output logic      out_valid,
  input  wire logic out_stall,
  output ctrl_cmd_t cmd
);

  typedef enum logic {
    S_IDLE,
    S_UPDATE
  } state_t;

  state_t state_r;
  state_t state_nxt;
  logic   out_valid_r;
  logic   out_valid_nxt;
  logic   out_free;

  assign in_stall   = (state_r != S_IDLE);
  assign out_free   = !out_valid_r || !out_stall;
  assign cmd.load   = in_valid && !in_stall;
  assign cmd.commit = (state_r == S_UPDATE) && out_free;

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r;
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
    case (state_r)
      S_IDLE: begin
        if (cmd.load) begin
          state_nxt = S_UPDATE;
        end
      end
      S_UPDATE: begin
        if (out_free) begin
          state_nxt     = S_IDLE;
          out_valid_nxt = 1'b1;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

`ifndef ASSERT_OFF
  a_busy_after_load: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |=> in_stall)
    else $error("accepted a beat while one is in flight");

  a_commit_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |=> out_valid)
    else $error("committed result not presented");
`endif

endmodule
`default_nettype wire

>>> rtl/bounded_unique_set_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bounded_unique_set_top
// bounded set of signed 32-bit values kept in insertion order, with add,
// remove, member query and read-by-index operations
// ----------------------------------------------------------------------------
// Each input beat carries one operation and yields exactly one result beat
// with found, stored, the entry count after the operation and, for a read,
// the entry. In the cycle a beat is accepted its value is compared against
// every live lane in parallel and the match vector is registered; the
// operation is then applied (append at the tail, or a one-place shift of
// the lanes above the single match) and the result register is loaded once
// it is free, so a result held by out_stall holds the commit. The input side
// then takes the next beat while the result still waits on the output. The
// store is empty after reset, with no clearing pass; capacity is cfg_wr_data,
// clamped to DEPTH, 10 after reset, and the user must write it only while no
// beat is in flight; the block itself does not enforce this.
// ----------------------------------------------------------------------------
module bounded_unique_set_top
  import bset_pkg::*;
#(
  parameter int DEPTH = 32
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  // input channel
  input  wire logic      in_valid,
  output logic           in_stall,
  input  wire in_item_t  in_data,
  // result channel
  output logic           out_valid,
  input  wire logic      out_stall,
  output out_item_t      out_data,
  // capacity register
  input  wire logic      cfg_wr_en,
  input  wire logic [5:0] cfg_wr_data
);

  ctrl_cmd_t cmd;

  // sequencing and result handshake
  bset_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  // entry lanes, compare, compaction and result register
  bset_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .in_data     (in_data),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .out_data    (out_data)
  );

endmodule
`default_nettype wire

>>> sim/bounded_unique_set_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bounded_unique_set_top_tb
// self-checking bench for the bounded unique set block
// ----------------------------------------------------------------------------
// A short table of hand-written beats covers the empty set, value extremes,
// duplicates, the full set, removal with compaction and reads past the count.
// Random beats follow in phases, each with its own capacity setting, drawn
// from a small value pool so that adds, removes and lookups hit stored
// entries. Every accepted beat is run through a behavioral copy of the set;
// results are compared field by field in order. Both handshakes see random
// gaps, except in one phase that runs at full rate.
// ----------------------------------------------------------------------------
module bounded_unique_set_top_tb;
  import bset_pkg::*;

  localparam int SET_DEPTH = 32;
  localparam int POOL_SIZE = 36;
  localparam int NUM_PHASES = 8;
  localparam int BEATS_PER_PHASE = 106;
  localparam logic signed [31:0] VAL_MAX = 32'sh7fff_ffff;
  localparam logic signed [31:0] VAL_MIN = 32'sh8000_0000;

  // one row of the directed table: the beat, and a hand-typed result where
  // it is obvious, otherwise the behavioral set decides
  typedef struct packed {
    in_item_t  beat;
    logic      typed;
    out_item_t want;
  } dir_row_t;

  localparam int DIR_ROWS = 25;
  localparam dir_row_t DIR_TABLE [DIR_ROWS] = '{
    // empty set after reset: nothing found, count stays zero
    '{'{OP_READ,   32'sd0, 5'd0},  1'b1, '{1'b0, 1'b0, 6'd0, 32'sd0}},
    '{'{OP_MEMBER, 32'sd0, 5'd31}, 1'b1, '{1'b0, 1'b0, 6'd0, 32'sd0}},
    '{'{OP_REMOVE, 32'sd0, 5'd0},  1'b1, '{1'b0, 1'b0, 6'd0, 32'sd0}},
    // value extremes, then a duplicate add that must be refused
    '{'{OP_ADD,    VAL_MAX, 5'd0},  1'b1, '{1'b0, 1'b1, 6'd1, 32'sd0}},
    '{'{OP_ADD,    VAL_MIN, 5'd31}, 1'b1, '{1'b0, 1'b1, 6'd2, 32'sd0}},
    '{'{OP_ADD,    VAL_MAX, 5'd0},  1'b1, '{1'b1, 1'b0, 6'd2, 32'sd0}},
    '{'{OP_MEMBER, VAL_MIN, 5'd0},  1'b1, '{1'b1, 1'b0, 6'd2, 32'sd0}},
    '{'{OP_READ,   VAL_MAX, 5'd1},  1'b1, '{1'b1, 1'b0, 6'd2, VAL_MIN}},
    // read at an index past the count
    '{'{OP_READ,   VAL_MIN, 5'd31}, 1'b1, '{1'b0, 1'b0, 6'd2, 32'sd0}},
    // remove present, then the same value again once it is gone
    '{'{OP_REMOVE, VAL_MAX, 5'd0},  1'b1, '{1'b1, 1'b0, 6'd1, 32'sd0}},
    '{'{OP_REMOVE, VAL_MAX, 5'd0},  1'b1, '{1'b0, 1'b0, 6'd1, 32'sd0}},
    '{'{OP_READ,   32'sd0,  5'd0},  1'b1, '{1'b1, 1'b0, 6'd1, VAL_MIN}},
    // fill up to the reset capacity of ten
    '{'{OP_ADD, 32'sd0,  5'd3},  1'b1, '{1'b0, 1'b1, 6'd2,  32'sd0}},
    '{'{OP_ADD, -32'sd1, 5'd7},  1'b1, '{1'b0, 1'b1, 6'd3,  32'sd0}},
    '{'{OP_ADD, 32'sd1,  5'd0},  1'b1, '{1'b0, 1'b1, 6'd4,  32'sd0}},
    '{'{OP_ADD, 32'sd2,  5'd0},  1'b1, '{1'b0, 1'b1, 6'd5,  32'sd0}},
    '{'{OP_ADD, 32'sd3,  5'd0},  1'b1, '{1'b0, 1'b1, 6'd6,  32'sd0}},
    '{'{OP_ADD, 32'sd4,  5'd0},  1'b1, '{1'b0, 1'b1, 6'd7,  32'sd0}},
    '{'{OP_ADD, 32'sd5,  5'd0},  1'b1, '{1'b0, 1'b1, 6'd8,  32'sd0}},
    '{'{OP_ADD, 32'sd6,  5'd0},  1'b1, '{1'b0, 1'b1, 6'd9,  32'sd0}},
    '{'{OP_ADD, 32'sd7,  5'd0},  1'b1, '{1'b0, 1'b1, 6'd10, 32'sd0}},
    // full set refuses a new value
    '{'{OP_ADD, 32'sd12345, 5'd0}, 1'b1, '{1'b0, 1'b0, 6'd10, 32'sd0}},
    // remove from the middle, then read across the closed gap
    '{'{OP_REMOVE, 32'sd3,     5'd0}, 1'b0, '0},
    '{'{OP_READ,   32'sd0,     5'd6}, 1'b0, '0},
    '{'{OP_ADD,    32'sd12345, 5'd0}, 1'b0, '0}
  };

  // capacity per random phase: max, lowered below the count, zero, beyond
  // the depth, one, just past the depth, mid-range, back to the reset value
  localparam logic [5:0] PHASE_CAP [NUM_PHASES] = '{
    6'd32, 6'd3, 6'd0, 6'd63, 6'd1, 6'd33, 6'd20, 6'd10
  };
  // share of adds in each phase, high where the set should fill up
  localparam int PHASE_ADD_PCT [NUM_PHASES] = '{70, 30, 40, 70, 50, 60, 45, 45};
  // phase that runs with no gaps on either side
  localparam int FULL_RATE_PHASE = 3;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_data;
  logic      cfg_wr_en = 1'b0;
  logic [5:0] cfg_wr_data = '0;

  // behavioral copy of the set
  logic signed [31:0] set_entries [SET_DEPTH];
  int                 set_count = 0;
  logic [5:0]         cap_reg = CAP_RESET;

  // results still owed by the block, oldest first
  out_item_t          results_owed [$];
  out_item_t          want_beat;
  logic signed [31:0] value_pool [POOL_SIZE];
  bit                 gaps_on = 1'b1;
  int                 mismatch_count = 0;
  int                 result_num = 0;

  bounded_unique_set_top #(
    .DEPTH(SET_DEPTH)
  ) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  always #5 clk = ~clk;

  task automatic report_mismatch(input string msg);
    $display("MISMATCH at %0t ns, result %0d: %s", $time, result_num, msg);
    mismatch_count++;
  endtask

  // applies one operation to the behavioral set and returns its result
  function automatic out_item_t apply_set_op(input in_item_t beat);
    out_item_t res;
    int        lim;
    int        keep;
    bit        hit;
    res = '0;
    hit = 1'b0;
    // capacity is clamped to the store depth; zero refuses every add
    lim = (cap_reg > SET_DEPTH) ? SET_DEPTH : int'(cap_reg);
    for (int i = 0; i < set_count; i++) begin
      if (set_entries[i] == beat.value) hit = 1'b1;
    end
    case (beat.operation)
      OP_ADD: begin
        res.found = hit;
        if (!hit && set_count < lim) begin
          set_entries[set_count] = beat.value;
          set_count++;
          res.stored = 1'b1;
        end
      end
      OP_REMOVE: begin
        // drop every match and slide the rest down, order kept
        res.found = hit;
        keep = 0;
        for (int i = 0; i < set_count; i++) begin
          if (set_entries[i] != beat.value) begin
            set_entries[keep] = set_entries[i];
            keep++;
          end
        end
        set_count = keep;
      end
      OP_MEMBER: begin
        res.found = hit;
      end
      OP_READ: begin
        if (int'(beat.index) < set_count) begin
          res.found = 1'b1;
          res.entry_value = set_entries[beat.index];
        end
      end
      default: ;
    endcase
    res.count = 6'(set_count);
    return res;
  endfunction

  // random beat: values mostly from the pool so that they collide with
  // stored entries; read indexes mostly near the live range
  function automatic in_item_t pick_set_op(input int add_pct);
    in_item_t beat;
    int       r;
    int       rest;
    int       top_idx;
    r = $urandom_range(99);
    rest = (100 - add_pct) / 3;
    if (r < add_pct) beat.operation = OP_ADD;
    else if (r < add_pct + rest) beat.operation = OP_REMOVE;
    else if (r < add_pct + 2 * rest) beat.operation = OP_MEMBER;
    else beat.operation = OP_READ;
    if ($urandom_range(9) == 0) beat.value = $urandom;
    else beat.value = value_pool[$urandom_range(POOL_SIZE - 1)];
    top_idx = (set_count > 31) ? 31 : set_count;
    if ($urandom_range(3) == 0) beat.index = 5'($urandom_range(31));
    else beat.index = 5'($urandom_range(top_idx));
    return beat;
  endfunction

  // drives one beat on the input channel; called and returns at a falling
  // edge, leaving valid high so back-to-back beats need no extra edge
  task automatic send_beat(input in_item_t beat, input logic typed,
                           input out_item_t typed_want);
    out_item_t predicted;
    while (gaps_on && $urandom_range(99) < 12) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= beat;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    // accepted at this edge: predict now so state follows beat order
    predicted = apply_set_op(beat);
    results_owed.push_back(typed ? typed_want : predicted);
    @(negedge clk);
  endtask

  // capacity may only change with nothing in flight
  task automatic set_capacity(input logic [5:0] cap);
    in_valid <= 1'b0;
    while (results_owed.size() != 0) @(negedge clk);
    repeat (3) @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= cap;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    cap_reg = cap;
  endtask

  // result side stalls at random, on the same gap switch as the input side
  always @(negedge clk) begin
    out_stall <= gaps_on && ($urandom_range(99) < 12);
  end

  // result checker: each accepted result against the oldest owed one
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (results_owed.size() == 0) begin
        report_mismatch($sformatf("result beat with none owed: %h", out_data));
      end else begin
        want_beat = results_owed.pop_front();
        if (out_data.found !== want_beat.found)
          report_mismatch($sformatf("found %b, want %b", out_data.found, want_beat.found));
        if (out_data.stored !== want_beat.stored)
          report_mismatch($sformatf("stored %b, want %b", out_data.stored,
                                    want_beat.stored));
        if (out_data.count !== want_beat.count)
          report_mismatch($sformatf("count %0d, want %0d", out_data.count,
                                    want_beat.count));
        if (out_data.entry_value !== want_beat.entry_value)
          report_mismatch($sformatf("entry_value %h, want %h", out_data.entry_value,
                                    want_beat.entry_value));
      end
      result_num++;
    end
  end

  // stimulus
  initial begin
    for (int i = 0; i < SET_DEPTH; i++) set_entries[i] = '0;
    // pool with the extremes, small numbers and random filler
    value_pool[0] = 32'sd0;
    value_pool[1] = -32'sd1;
    value_pool[2] = VAL_MIN;
    value_pool[3] = VAL_MAX;
    value_pool[4] = 32'sd1;
    for (int i = 5; i < POOL_SIZE; i++) value_pool[i] = $urandom;

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed table at the reset capacity
    for (int i = 0; i < DIR_ROWS; i++)
      send_beat(DIR_TABLE[i].beat, DIR_TABLE[i].typed, DIR_TABLE[i].want);

    // random phases, each under its own capacity
    for (int p = 0; p < NUM_PHASES; p++) begin
      set_capacity(PHASE_CAP[p]);
      gaps_on = (p != FULL_RATE_PHASE);
      for (int n = 0; n < BEATS_PER_PHASE; n++)
        send_beat(pick_set_op(PHASE_ADD_PCT[p]), 1'b0, '0);
    end

    // drain, then keep watching for stray results
    in_valid <= 1'b0;
    gaps_on = 1'b1;
    while (results_owed.size() != 0) @(negedge clk);
    repeat (10) @(negedge clk);
    if (mismatch_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // watchdog, far beyond the slowest legal run
  initial begin
    #(2_000_000);
    $display("end of test: mismatches");
    $finish;
  end

endmodule
